// File: rtl/ptc_pkg.sv
// Package for the trial-division prime test counter.
// Holds the fixed result widths and the command/status structs shared by
// the controller and the datapath. No dependencies.
package ptc_pkg;

  // Result widths
  localparam int COUNT_W     = 16;
  localparam int OUT_TDATA_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the request, set divisor to two
    logic start_div;  // clear remainder, load bit counter with top index
    logic div_step;   // one restoring remainder step
    logic next_div;   // advance divisor and its square
    logic finish;     // write result register and update count
    logic prime;      // flag written on finish
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lt_two;     // value is zero or one
    logic sq_over;    // divisor squared exceeds value
    logic div_last;   // current step is the last remainder step
    logic rem_zero;   // divisor divides value
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

// File: rtl/ptc_ctrl.sv
// Controller state machine for the prime test counter.
// Sequences divisor checks and remainder steps; depends on ptc_pkg.
module ptc_ctrl
  import ptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_DONE_P = 3'd4;
  localparam logic [2:0] ST_DONE_N = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state) inside
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.lt_two) begin
          state_next = ST_DONE_N;
        end else if (status.sq_over) begin
          state_next = ST_DONE_P;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.rem_zero) begin
          state_next = ST_DONE_N;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_DONE_P, ST_DONE_N: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          cmd.prime  = (state == ST_DONE_P);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/ptc_dpath.sv
// Datapath for the prime test counter: divisor, running square, bit-serial
// remainder unit, prime count and result register. Depends on ptc_pkg.
module ptc_dpath
  import ptc_pkg::*;
#(
  parameter int VALUE_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] in_value,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_is_prime,
  output logic [COUNT_W-1:0]    out_total
);

  // Divisor never passes 2**ceil(VALUE_BITS/2)
  localparam int DW = (VALUE_BITS + 1) / 2 + 1;
  localparam int SW = 2 * DW;
  localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] value;
  logic [DW-1:0]         divisor;
  logic [SW-1:0]         square;
  logic [DW-1:0]         rem;
  logic [BW-1:0]         bit_idx;
  logic [COUNT_W-1:0]    count;
  logic                  is_prime;
  logic                  valid;

  logic [DW:0]           rem_shift;
  logic                  rem_ge;

  // One restoring remainder step, high bit first
  assign rem_shift = {rem, value[bit_idx]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});

  assign status.lt_two   = (value < VALUE_BITS'(2));
  assign status.sq_over  = (square > SW'(value));
  assign status.div_last = (bit_idx == '0);
  assign status.rem_zero = (rem == '0);
  assign status.out_free = !valid || out_ready;

  // Trial loop registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= in_value;
      divisor <= DW'(2);
      square  <= SW'(4);
    end else if (cmd.next_div) begin
      divisor <= divisor + DW'(1);
      square  <= square + SW'({divisor, 1'b0}) + SW'(1);
    end
    if (cmd.start_div) begin
      rem     <= '0;
      bit_idx <= BW'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? DW'(rem_shift - {1'b0, divisor}) : DW'(rem_shift);
      bit_idx <= bit_idx - BW'(1);
    end
  end

  // Result flag
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_prime <= cmd.prime;
    end
  end

  // Count and result valid; count only moves when a new result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        valid <= 1'b1;
        if (cmd.prime && (count != COUNT_MAX)) begin
          count <= count + COUNT_W'(1);
        end
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  assign out_valid    = valid;
  assign out_is_prime = is_prime;
  assign out_total    = count;

endmodule

// File: rtl/prime_test_counter_core.sv
// Trial-division prime tester with a saturating count of primes found.
// Each request runs trial divisors in turn, each through a bit-serial remainder
// over the value bits, until one divides the value or its square exceeds it
// (up to 180 divisors at 15 bits).
// One request at a time; a finished result waits in the output register.
// Synchronous active-high reset clears the count and drops the result valid.
module prime_test_counter_core
  import ptc_pkg::*;
#(
  parameter int VALUE_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // value
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // is_prime, prime_total[15:0], zero pad
  output logic [OUT_TDATA_W-1:0]            m_tdata
);

  cmd_t               cmd;
  status_t            status;
  logic               is_prime;
  logic [COUNT_W-1:0] total;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptc_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .in_value     (s_tdata[VALUE_BITS-1:0]),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_is_prime (is_prime),
    .out_total    (total)
  );

  // Pack the result
  assign m_tdata = {{(OUT_TDATA_W - COUNT_W - 1){1'b0}}, total, is_prime};

endmodule

// File: rtl/ptc_checker.sv
// Port-level checks for prime_test_counter_core, bound to the top level.
// Depends on ptc_pkg.
module ptc_checker
  import ptc_pkg::*;
(
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [OUT_TDATA_W-1:0]          m_tdata
);

  logic [COUNT_W-1:0] last_total;
  logic [COUNT_W-1:0] expect_total;

  // Track the total of the last result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (m_tvalid && m_tready) begin
      last_total <= m_tdata[COUNT_W:1];
    end
  end

  assign expect_total = (last_total == COUNT_MAX) ? last_total :
                        last_total + COUNT_W'(m_tdata[0]);

  // No result right after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Count moves by the prime flag, saturating
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |-> (m_tdata[COUNT_W:1] == expect_total))
    else $error("prime total out of step");

  // One request in flight
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while busy");

endmodule

bind prime_test_counter_core ptc_checker u_ptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/prime_result_checker.sv
// Checker for the prime test counter: watches both stream channels, predicts
// the prime flag and running prime count per request, and compares results.
// Depends on ptc_pkg for the count width, its maximum and the result width.
module prime_result_checker
  import ptc_pkg::*;
#(
  parameter int VALUE_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // value
  input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // is_prime, prime_total[15:0], zero pad
  input  logic [OUT_TDATA_W-1:0]          m_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen,
  output int                              primes_seen
);

  typedef struct packed {
    logic               prime;
    logic [COUNT_W-1:0] total;
  } verdict_t;

  localparam int PAD_W = OUT_TDATA_W - COUNT_W - 1;

  verdict_t           pending_verdicts[$];
  logic [COUNT_W-1:0] prime_tally;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    primes_seen  = 0;
    prime_tally  = '0;
  end

  // Trial division: 0 and 1 are not prime, divisors run while d*d <= v
  function automatic logic is_prime_value(input logic [VALUE_BITS-1:0] v);
    longint unsigned n;
    n = 64'(v);
    if (n < 2) return 1'b0;
    for (longint unsigned d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  // Predict on each request, check on each result
  always @(posedge clk) begin
    verdict_t           want;
    logic [VALUE_BITS-1:0] v;
    logic               got_prime;
    logic [COUNT_W-1:0] got_total;
    logic [PAD_W-1:0]   got_pad;
    string              bad;
    if (rst) begin
      pending_verdicts.delete();
      prime_tally = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        // bits above the value field are ignored by the block
        v = s_tdata[VALUE_BITS-1:0];
        want.prime = is_prime_value(v);
        if (want.prime && prime_tally != COUNT_MAX) prime_tally = prime_tally + COUNT_W'(1);
        want.total = prime_tally;
        pending_verdicts.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got_prime = m_tdata[0];
        got_total = m_tdata[COUNT_W:1];
        got_pad   = m_tdata[OUT_TDATA_W-1:COUNT_W+1];
        results_seen++;
        if (got_prime) primes_seen++;
        if (pending_verdicts.size() == 0) begin
          report($sformatf("result with no request outstanding (tdata=%h)", m_tdata));
        end else begin
          want = pending_verdicts.pop_front();
          bad  = "";
          if (got_prime !== want.prime)
            bad = {bad, $sformatf(" is_prime got %0d want %0d", got_prime, want.prime)};
          if (got_total !== want.total)
            bad = {bad, $sformatf(" prime_total got %0d want %0d", got_total, want.total)};
          if (got_pad !== '0)
            bad = {bad, $sformatf(" pad bits got %h", got_pad)};
          if (bad != "") report($sformatf("result %0d:%s", results_seen, bad));
        end
      end
    end
    pending = pending_verdicts.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the prime test counter testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on ptc_pkg, the core
// and prime_result_checker, which does all prediction and comparison.
module tb_top
  import ptc_pkg::*;
();

  localparam int VALUE_BITS     = 15;
  localparam int IN_W           = ((VALUE_BITS+7)/8)*8;
  localparam int RAND_PER_PHASE = 66;
  // limit allows several times the slowest request, plus stalls
  localparam int STALL_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 3100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int results_seen;
  int primes_seen;
  int snd_idle_pct = 20;
  int rcv_idle_pct = 86;
  int requests_sent = 0;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  prime_test_counter_core #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  prime_result_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .primes_seen  (primes_seen)
  );

  // Back-pressure the result channel at the current idle rate
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Present one request from a falling edge, hold until accepted
  task automatic send_value(input logic [IN_W-1:0] word);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] directed_vals[$];
    logic [IN_W-1:0] word;
    int              root;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero and one, small primes and squares, field extremes,
    // largest 15-bit prime and square, stray bits above the value field
    directed_vals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25,
                      16'd31, 16'd49, 16'd169, 16'd16384, 16'h5555, 16'h2AAA,
                      16'd32749, 16'd32761, 16'd32762, 16'h7FFF,
                      16'h8000, 16'h8001, 16'h8007, 16'hFFFF};
    foreach (directed_vals[i]) send_value(directed_vals[i]);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 20; rcv_idle_pct = 86; end
        1: begin snd_idle_pct = 86; rcv_idle_pct = 20; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        case ($urandom_range(0, 9)) inside
          [0:3]: word = IN_W'($urandom_range(0, 65535));
          [4:5]: word = IN_W'($urandom_range(0, 255));
          [6:7]: begin
            // around a perfect square: stresses the last trial divisor
            root = $urandom_range(2, 181);
            word = IN_W'(root * root + $urandom_range(0, 2) - 1);
          end
          8:       word = IN_W'(32767 - $urandom_range(0, 200));
          default: word = {1'b1, 15'($urandom_range(0, 32767))};
        endcase
        send_value(word);
      end
      wait_drained();
    end

    // Watch for stray results after the last one
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests (%0d directed, rest random over three flow-control mixes).",
             requests_sent, directed_vals.size());
    $display("Checked %0d results, %0d flagged prime; mismatches: %0d.",
             results_seen, primes_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
